/* rtl/core/srb_pkg.sv */
// Shared types and constants for the serial ring buffer block.
package srb_pkg;

	// Item action codes
	typedef enum logic [2:0] {
		ACT_RX_BYTE  = 3'd0,
		ACT_GET      = 3'd1,
		ACT_PUT      = 3'd2,
		ACT_TX_READY = 3'd3,
		ACT_CLR_LINE = 3'd4
	} srb_action_t;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_RESP = 2'd2
	} srb_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;  // capture the incoming word
		logic exec;  // apply the action to the rings
	} srb_cmd_t;

endpackage

/* rtl/core/srb_ctrl.sv */
// Controller state machine: sequences capture, execute and response of one word.
module srb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output srb_pkg::srb_cmd_t cmd
);

	srb_pkg::srb_state_t state_q;
	srb_pkg::srb_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			srb_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = srb_pkg::ST_EXEC;
				end
			end
			srb_pkg::ST_EXEC: begin
				state_nxt = srb_pkg::ST_RESP;
			end
			srb_pkg::ST_RESP: begin
				if (m_tready) begin
					state_nxt = srb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = srb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			srb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			srb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			srb_pkg::ST_RESP: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/srb_datapath.sv */
// Datapath: both ring memories, their pointers, the line flag and the result register.
module srb_datapath #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srb_pkg::srb_cmd_t                   cmd,
	input  logic [srb_pkg::IN_TDATA_W-1:0]      in_word,
	output logic [srb_pkg::OUT_TDATA_W-1:0]     out_word
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [2:0]       act_q;
	logic [7:0]       data_q;
	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic             line_q;
	logic             valid_q;
	logic             drop_q;
	logic             src_tx_q;
	logic [7:0]       rx_rd_q, tx_rd_q;

	logic [7:0] rx_mem [RING_DEPTH];
	logic [7:0] tx_mem [RING_DEPTH];

	logic [PTR_W-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
	logic             rx_empty, tx_empty, rx_full, tx_full;
	logic             rx_wr, tx_wr, rx_rd, tx_rd;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	assign rx_head_inc = ptr_next(rx_head_q);
	assign rx_tail_inc = ptr_next(rx_tail_q);
	assign tx_head_inc = ptr_next(tx_head_q);
	assign tx_tail_inc = ptr_next(tx_tail_q);
	assign rx_empty    = (rx_head_q == rx_tail_q);
	assign tx_empty    = (tx_head_q == tx_tail_q);
	assign rx_full     = (rx_head_inc == rx_tail_q);
	assign tx_full     = (tx_head_inc == tx_tail_q);

	assign rx_wr = cmd.exec && (act_q == srb_pkg::ACT_RX_BYTE);
	assign tx_wr = cmd.exec && (act_q == srb_pkg::ACT_PUT);
	assign rx_rd = cmd.exec && (act_q == srb_pkg::ACT_GET) && !rx_empty;
	assign tx_rd = cmd.exec && (act_q == srb_pkg::ACT_TX_READY) && !tx_empty;

	// incoming word: action in bits 2:0, data byte in bits 10:3
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_word[2:0];
			data_q <= in_word[10:3];
		end
	end

	always_ff @(posedge clk) begin
		if (rx_wr) begin
			rx_mem[rx_head_q] <= data_q;
		end
		if (rx_rd) begin
			rx_rd_q <= rx_mem[rx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_wr) begin
			tx_mem[tx_head_q] <= data_q;
		end
		if (tx_rd) begin
			tx_rd_q <= tx_mem[tx_tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			line_q    <= 1'b0;
			valid_q   <= 1'b0;
			drop_q    <= 1'b0;
			src_tx_q  <= 1'b0;
		end else if (cmd.exec) begin
			valid_q  <= rx_rd || tx_rd;
			src_tx_q <= tx_rd;
			drop_q   <= (rx_wr && rx_full) || (tx_wr && tx_full);
			case (act_q)
				srb_pkg::ACT_RX_BYTE: begin
					rx_head_q <= rx_head_inc;
					// full ring: oldest byte is overwritten
					if (rx_full) begin
						rx_tail_q <= rx_tail_inc;
					end
					if (data_q == srb_pkg::NEWLINE_BYTE) begin
						line_q <= 1'b1;
					end
				end
				srb_pkg::ACT_GET: begin
					if (!rx_empty) begin
						rx_tail_q <= rx_tail_inc;
					end
				end
				srb_pkg::ACT_PUT: begin
					tx_head_q <= tx_head_inc;
					if (tx_full) begin
						tx_tail_q <= tx_tail_inc;
					end
				end
				srb_pkg::ACT_TX_READY: begin
					if (!tx_empty) begin
						tx_tail_q <= tx_tail_inc;
					end
				end
				srb_pkg::ACT_CLR_LINE: begin
					line_q <= 1'b0;
				end
				default: begin
					line_q <= line_q;
				end
			endcase
		end
	end

	logic [7:0] out_byte;
	assign out_byte = !valid_q ? 8'h00 : (src_tx_q ? tx_rd_q : rx_rd_q);

	assign out_word = {3'b000, tx_empty, rx_empty, drop_q, line_q, valid_q, out_byte};

	a_rx_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rx_wr |=> !rx_empty) else $error("rx ring empty after a receive");

	a_tx_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		tx_wr |=> !tx_empty) else $error("tx ring empty after a put");

	a_valid_only_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && act_q != srb_pkg::ACT_GET && act_q != srb_pkg::ACT_TX_READY)
		|=> !valid_q) else $error("valid result without a read action");

	a_empty_get_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && act_q == srb_pkg::ACT_GET && rx_empty)
		|=> !valid_q && $stable(rx_tail_q)) else $error("get from empty rx ring moved state");

	a_drop_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !rx_wr && !tx_wr) |=> !drop_q) else $error("drop without a push");

endmodule

/* rtl/core/serial_ring_buffers_drop_oldest.sv */
// A word passes through capture, ring update with registered memory read and
// result, and the result then waits on m_tready as long as it is low; the result
// word is offered after the ring update, and the next input word can be accepted
// in the cycle after the result is taken, so one word is in flight at a time.
// Action codes: 0 line byte received, 1 get, 2 put, 3 transmitter ready, 4 clear
// line flag, 5 to 7 ignored. Each ring holds RING_DEPTH-1 bytes and overwrites
// its oldest byte when full; the rings need no clearing after reset.
module serial_ring_buffers_drop_oldest #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // action[2:0], data_byte[10:3], zero[15:11]
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0], out_valid[8], line_seen[9], dropped[10], rx_empty[11],
	// tx_empty[12], zero[15:13]
	output logic [15:0] m_tdata
);

	srb_pkg::srb_cmd_t cmd;

	srb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	srb_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (s_tdata),
		.out_word (m_tdata)
	);

endmodule

/* tb/srb_ring_checker.sv */
`timescale 1ns / 1ps
// Checker for the serial ring buffers: predicts every result word and compares it.
module srb_ring_checker #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	localparam int unsigned RX = 0;
	localparam int unsigned TX = 1;

	// field order matches m_tdata from bit 12 down
	typedef struct packed {
		logic       tx_empty;
		logic       rx_empty;
		logic       dropped;
		logic       line_seen;
		logic       out_valid;
		logic [7:0] out_byte;
	} ring_result_t;

	logic [7:0]   ring_mem [2][RING_DEPTH];
	int unsigned  wr_idx [2];
	int unsigned  rd_idx [2];
	logic         line_flag;
	ring_result_t ring_results_q [$];
	int           errors = 0;

	function automatic int unsigned next_idx(input int unsigned p);
		return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
	endfunction

	// full ring: oldest byte goes first, then the new byte lands
	task automatic push_byte(input int unsigned r, input logic [7:0] b, output logic drop);
		drop = 1'b0;
		if (next_idx(wr_idx[r]) == rd_idx[r]) begin
			rd_idx[r] = next_idx(rd_idx[r]);
			drop = 1'b1;
		end
		ring_mem[r][wr_idx[r]] = b;
		wr_idx[r] = next_idx(wr_idx[r]);
	endtask

	task automatic pop_byte(input int unsigned r, output logic [7:0] b, output logic ok);
		if (wr_idx[r] == rd_idx[r]) begin
			b = 8'h00;
			ok = 1'b0;
		end else begin
			b = ring_mem[r][rd_idx[r]];
			rd_idx[r] = next_idx(rd_idx[r]);
			ok = 1'b1;
		end
	endtask

	task automatic predict_ring_word(input logic [15:0] word, output ring_result_t res);
		logic [2:0] act;
		logic [7:0] b;
		logic [7:0] ob;
		logic       drop;
		logic       ok;
		act = word[2:0];
		b = word[10:3];
		ob = 8'h00;
		drop = 1'b0;
		ok = 1'b0;
		case (act)
			srb_pkg::ACT_RX_BYTE: begin
				push_byte(RX, b, drop);
				if (b == srb_pkg::NEWLINE_BYTE)
					line_flag = 1'b1;
			end
			srb_pkg::ACT_GET:      pop_byte(RX, ob, ok);
			srb_pkg::ACT_PUT:      push_byte(TX, b, drop);
			srb_pkg::ACT_TX_READY: pop_byte(TX, ob, ok);
			srb_pkg::ACT_CLR_LINE: line_flag = 1'b0;
			default: ;
		endcase
		res.out_byte = ob;
		res.out_valid = ok;
		res.line_seen = line_flag;
		res.dropped = drop;
		res.rx_empty = (wr_idx[RX] == rd_idx[RX]);
		res.tx_empty = (wr_idx[TX] == rd_idx[TX]);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		errors++;
		$display("mismatch @%0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ring_result_t want;
		ring_result_t got;
		if (!arst_n) begin
			wr_idx[RX] = 0;
			rd_idx[RX] = 0;
			wr_idx[TX] = 0;
			rd_idx[TX] = 0;
			line_flag = 1'b0;
			ring_results_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[12:0];
				if (ring_results_q.size() == 0) begin
					report_mismatch("word with none expected", m_tdata[7:0], 8'h00);
				end else begin
					want = ring_results_q.pop_front();
					check_field("out_byte", got.out_byte, want.out_byte);
					check_field("out_valid", {7'b0, got.out_valid}, {7'b0, want.out_valid});
					check_field("line_seen", {7'b0, got.line_seen}, {7'b0, want.line_seen});
					check_field("dropped", {7'b0, got.dropped}, {7'b0, want.dropped});
					check_field("rx_empty", {7'b0, got.rx_empty}, {7'b0, want.rx_empty});
					check_field("tx_empty", {7'b0, got.tx_empty}, {7'b0, want.tx_empty});
					check_field("pad", {5'b0, m_tdata[15:13]}, 8'h00);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_ring_word(s_tdata, want);
				ring_results_q.push_back(want);
			end
		end
		fail_count <= errors;
		pending <= ring_results_q.size();
	end

endmodule

/* tb/serial_ring_buffers_drop_oldest_tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for the serial ring buffers: stimulus, handshakes and verdict.
module serial_ring_buffers_drop_oldest_tb;

	localparam int unsigned RING_DEPTH  = 64;
	localparam int unsigned WORD_TARGET = 800;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned IDLE_PCT    = 19;
	localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [15:0] m_tdata;

	int          fail_count;
	int          pending;
	bit          idle_on = 1'b1;
	int unsigned words_sent = 0;
	int unsigned cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	serial_ring_buffers_drop_oldest #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	srb_ring_checker #(
		.RING_DEPTH(RING_DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// newlines often enough to keep the line flag moving
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0)
			return srb_pkg::NEWLINE_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [2:0] act, input logic [7:0] b);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, b, act};
		do
			@(posedge clk);
		while (!s_tready);
		if (act <= srb_pkg::ACT_CLR_LINE)
			words_sent++;
	endtask

	initial begin
		logic [2:0]  act;
		int unsigned n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty rings, then edge bytes and the newline flag
		send_word(srb_pkg::ACT_GET, 8'h00);
		send_word(srb_pkg::ACT_TX_READY, 8'hFF);
		send_word(srb_pkg::ACT_CLR_LINE, 8'h00);
		send_word(srb_pkg::ACT_RX_BYTE, 8'h00);
		send_word(srb_pkg::ACT_RX_BYTE, 8'hFF);
		send_word(srb_pkg::ACT_RX_BYTE, srb_pkg::NEWLINE_BYTE);
		send_word(ACT_UNUSED_LO, 8'hA5);
		send_word(ACT_UNUSED_LO + 3'd1, 8'h5A);
		send_word(ACT_UNUSED_HI, 8'hFF);
		repeat (4) send_word(srb_pkg::ACT_GET, 8'hFF);
		send_word(srb_pkg::ACT_CLR_LINE, 8'hFF);
		send_word(srb_pkg::ACT_PUT, 8'h00);
		send_word(srb_pkg::ACT_PUT, 8'hFF);
		send_word(srb_pkg::ACT_PUT, srb_pkg::NEWLINE_BYTE);
		repeat (4) send_word(srb_pkg::ACT_TX_READY, 8'h00);

		// overfill each ring so the oldest bytes get dropped, then drain past empty
		repeat (RING_DEPTH + 1) send_word(srb_pkg::ACT_RX_BYTE, pick_byte());
		repeat (RING_DEPTH) send_word(srb_pkg::ACT_GET, 8'($urandom_range(0, 255)));
		repeat (RING_DEPTH + 1) send_word(srb_pkg::ACT_PUT, pick_byte());
		repeat (RING_DEPTH) send_word(srb_pkg::ACT_TX_READY, 8'($urandom_range(0, 255)));

		while (words_sent < WORD_TARGET) begin
			idle_on = !(words_sent >= 350 && words_sent < 500);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					act = $urandom_range(0, 1) ? srb_pkg::ACT_RX_BYTE : srb_pkg::ACT_PUT;
					n = $urandom_range(1, RING_DEPTH + 8);
					repeat (n) send_word(act, pick_byte());
				end
				3, 4: begin
					act = $urandom_range(0, 1) ? srb_pkg::ACT_GET : srb_pkg::ACT_TX_READY;
					n = $urandom_range(1, RING_DEPTH + 4);
					repeat (n) send_word(act, 8'($urandom_range(0, 255)));
				end
				5, 6, 7, 8: begin
					n = $urandom_range(1, 20);
					repeat (n) send_word(3'($urandom_range(srb_pkg::ACT_RX_BYTE,
						srb_pkg::ACT_CLR_LINE)), pick_byte());
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				end
			endcase
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
